FILE: rtl/core/ssisd_pkg.sv
// ----------------------------------------------------------------------------
// Sorted set package
// Shared widths, codes and control types for the sorted set block.
// ----------------------------------------------------------------------------
package ssisd_pkg;

    localparam int VALUE_W     = 31;
    localparam int OP_W        = 2;
    localparam int STATUS_W    = 2;
    localparam int POSITION_W  = 10;
    localparam int COUNT_W     = 11;
    localparam int IN_TDATA_W  = 40;
    localparam int OUT_TDATA_W = 24;
    localparam int CAPACITY_DEF = 1024;

    typedef enum logic [OP_W-1:0] {
        OP_INSERT = 2'd0,
        OP_SEARCH = 2'd1,
        OP_DELETE = 2'd2
    } op_t;

    typedef enum logic [STATUS_W-1:0] {
        ST_OK        = 2'd0,
        ST_NOT_FOUND = 2'd1,
        ST_FULL      = 2'd2
    } status_t;

    // Shift command broadcast to every cell.
    typedef struct packed {
        logic ins;
        logic del;
    } ssisd_cmd_t;

    // Status of the search unit.
    typedef struct packed {
        logic done;
        logic found;
    } ssisd_srch_t;

endpackage

FILE: rtl/core/ssisd_cell.sv
// ----------------------------------------------------------------------------
// Sorted set cell
// Holds one entry, compares it with the current key and shifts with its
// neighbors on insert and delete.
// ----------------------------------------------------------------------------
module ssisd_cell
    import ssisd_pkg::*;
#(
    parameter int IW    = 10,
    parameter int INDEX = 0
)
(
    input  logic               clk,
    input  logic [VALUE_W-1:0] value,
    input  logic [VALUE_W-1:0] left_entry,
    input  logic [VALUE_W-1:0] right_entry,
    input  ssisd_cmd_t         cmd,
    input  logic [IW-1:0]      idx,
    output logic [VALUE_W-1:0] entry,
    output logic               lt,
    output logic               eq
);

    localparam logic [IW-1:0] MY_IDX = IW'(INDEX);

    logic [VALUE_W-1:0] entry_reg;
    logic [VALUE_W-1:0] entry_next;
    logic               lt_reg;
    logic               eq_reg;

    always_comb
    begin
        entry_next = entry_reg;
        if (cmd.ins)
        begin
            if (MY_IDX > idx)
            begin
                entry_next = left_entry;
            end
            else if (MY_IDX == idx)
            begin
                entry_next = value;
            end
        end
        else if (cmd.del && (MY_IDX >= idx))
        begin
            entry_next = right_entry;
        end
    end

    always_ff @(posedge clk)
    begin
        entry_reg <= entry_next;
        lt_reg    <= (entry_reg < value);
        eq_reg    <= (entry_reg == value);
    end

    assign entry = entry_reg;
    assign lt    = lt_reg;
    assign eq    = eq_reg;

endmodule

FILE: rtl/core/ssisd_search.sv
// ----------------------------------------------------------------------------
// Sorted set search unit
// Binary search over the registered compare flags of the cells, one
// midpoint per cycle, in lower-bound or exact-match mode.
// ----------------------------------------------------------------------------
module ssisd_search
    import ssisd_pkg::*;
#(
    parameter int CAPACITY = CAPACITY_DEF,
    parameter int IW       = 10,
    parameter int CW       = 11
)
(
    input  logic                clk,
    input  logic                rst_n,
    input  logic                start,
    input  logic                find_mode,
    input  logic [CW-1:0]       count,
    input  logic [CAPACITY-1:0] lt,
    input  logic [CAPACITY-1:0] eq,
    output ssisd_srch_t         stat,
    output logic [IW-1:0]       idx
);

    logic          busy_reg;
    logic          busy_next;
    logic          mode_reg;
    logic          mode_next;
    logic [CW-1:0] lo_reg;
    logic [CW-1:0] lo_next;
    logic [CW-1:0] hi_reg;
    logic [CW-1:0] hi_next;
    logic          done_reg;
    logic          done_next;
    logic          found_reg;
    logic          found_next;
    logic [IW-1:0] idx_reg;
    logic [IW-1:0] idx_next;
    logic [CW:0]   sum;
    logic [IW-1:0] mid;

    assign sum = {1'b0, lo_reg} + {1'b0, hi_reg} - {{CW{1'b0}}, mode_reg};
    assign mid = sum[IW:1];

    always_comb
    begin
        busy_next  = busy_reg;
        mode_next  = mode_reg;
        lo_next    = lo_reg;
        hi_next    = hi_reg;
        done_next  = 1'b0;
        found_next = found_reg;
        idx_next   = idx_reg;
        if (start)
        begin
            busy_next  = 1'b1;
            mode_next  = find_mode;
            lo_next    = '0;
            hi_next    = count;
            found_next = 1'b0;
        end
        else if (busy_reg)
        begin
            if (lo_reg < hi_reg)
            begin
                if (mode_reg && eq[mid])
                begin
                    busy_next  = 1'b0;
                    done_next  = 1'b1;
                    found_next = 1'b1;
                    idx_next   = mid;
                end
                else if (lt[mid])
                begin
                    lo_next = CW'(mid) + CW'(1);
                end
                else
                begin
                    hi_next = CW'(mid);
                end
            end
            else
            begin
                busy_next  = 1'b0;
                done_next  = 1'b1;
                found_next = 1'b0;
                idx_next   = IW'(lo_reg);
            end
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            busy_reg  <= 1'b0;
            mode_reg  <= 1'b0;
            lo_reg    <= '0;
            hi_reg    <= '0;
            done_reg  <= 1'b0;
            found_reg <= 1'b0;
            idx_reg   <= '0;
        end
        else
        begin
            busy_reg  <= busy_next;
            mode_reg  <= mode_next;
            lo_reg    <= lo_next;
            hi_reg    <= hi_next;
            done_reg  <= done_next;
            found_reg <= found_next;
            idx_reg   <= idx_next;
        end
    end

    assign stat.done  = done_reg;
    assign stat.found = found_reg;
    assign idx        = idx_reg;

endmodule

FILE: rtl/core/sorted_set_insert_search_delete.sv
// ----------------------------------------------------------------------------
// Sorted set with insert, search and delete
// Ascending list of 31-bit identifiers held in a row of shifting cells.
// ----------------------------------------------------------------------------
// One beat is taken at a time. The cells register the compare of every entry
// with the key, then a binary search unit walks the registered compare flags
// one midpoint per cycle, and the cells then shift. The number of search steps
// grows with the count of entries. The result register is loaded only once the
// output is free, so a stalled result beat holds up the block. The next input
// beat can be taken in the cycle after the result register is loaded.
// Duplicates are kept; search and delete report the first match the binary
// search reaches. An insert into a full list is refused with status full.
module sorted_set_insert_search_delete
    import ssisd_pkg::*;
#(
    parameter int CAPACITY = CAPACITY_DEF
)
(
    input  logic                   clk,
    input  logic                   rst_n,
    input  logic                   s_tvalid,
    output logic                   s_tready,
    // op [1:0], value [32:2], zero fill above.
    input  logic [IN_TDATA_W-1:0]  s_tdata,
    output logic                   m_tvalid,
    input  logic                   m_tready,
    // status [1:0], position [11:2], count [22:12], zero fill above.
    output logic [OUT_TDATA_W-1:0] m_tdata
);

    localparam int IW = (CAPACITY > 1) ? $clog2(CAPACITY) : 1;
    localparam int CW = $clog2(CAPACITY + 1);

    typedef enum logic [2:0] {
        S_IDLE,
        S_CMP,
        S_SRCH,
        S_APPLY,
        S_RESULT
    } state_t;

    state_t                 state_reg;
    logic [OP_W-1:0]        op_reg;
    logic [VALUE_W-1:0]     value_reg;
    logic [CW-1:0]          count_reg;
    status_t                res_status_reg;
    logic [POSITION_W-1:0]  res_pos_reg;
    logic                   m_tvalid_reg;
    logic [OUT_TDATA_W-1:0] m_tdata_reg;

    logic [VALUE_W-1:0]     entry_w [CAPACITY];
    logic [CAPACITY-1:0]    lt_w;
    logic [CAPACITY-1:0]    eq_w;
    ssisd_cmd_t             cmd;
    ssisd_srch_t            srch;
    logic [IW-1:0]          srch_idx;
    logic                   not_full;
    logic                   out_free;

    assign not_full = (count_reg < CW'(CAPACITY));
    assign out_free = !m_tvalid_reg || m_tready;
    assign cmd.ins  = (state_reg == S_APPLY) && (op_reg == OP_INSERT) && not_full;
    assign cmd.del  = (state_reg == S_APPLY) && (op_reg == OP_DELETE) && srch.found;

    for (genvar i = 0; i < CAPACITY; i++)
    begin : g_cell
        logic [VALUE_W-1:0] left_w;
        logic [VALUE_W-1:0] right_w;
        if (i == 0)
        begin : g_first
            assign left_w = '0;
        end
        else
        begin : g_left
            assign left_w = entry_w[i-1];
        end
        if (i == CAPACITY - 1)
        begin : g_last
            assign right_w = '0;
        end
        else
        begin : g_right
            assign right_w = entry_w[i+1];
        end
        ssisd_cell #(
            .IW    (IW),
            .INDEX (i)
        ) u_cell (
            .clk         (clk),
            .value       (value_reg),
            .left_entry  (left_w),
            .right_entry (right_w),
            .cmd         (cmd),
            .idx         (srch_idx),
            .entry       (entry_w[i]),
            .lt          (lt_w[i]),
            .eq          (eq_w[i])
        );
    end

    ssisd_search #(
        .CAPACITY (CAPACITY),
        .IW       (IW),
        .CW       (CW)
    ) u_search (
        .clk       (clk),
        .rst_n     (rst_n),
        .start     (state_reg == S_CMP),
        .find_mode (op_reg != OP_INSERT),
        .count     (count_reg),
        .lt        (lt_w),
        .eq        (eq_w),
        .stat      (srch),
        .idx       (srch_idx)
    );

    always_ff @(posedge clk)
    begin
        if (s_tvalid && s_tready)
        begin
            op_reg    <= s_tdata[OP_W-1:0];
            value_reg <= s_tdata[OP_W +: VALUE_W];
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg      <= S_IDLE;
            count_reg      <= '0;
            res_status_reg <= ST_NOT_FOUND;
            res_pos_reg    <= '0;
            m_tvalid_reg   <= 1'b0;
            m_tdata_reg    <= '0;
        end
        else
        begin
            if (m_tvalid_reg && m_tready && (state_reg != S_RESULT))
            begin
                m_tvalid_reg <= 1'b0;
            end
            case (state_reg)
                S_IDLE:
                begin
                    if (s_tvalid)
                    begin
                        state_reg <= S_CMP;
                    end
                end
                S_CMP:
                begin
                    state_reg <= S_SRCH;
                end
                S_SRCH:
                begin
                    if (srch.done)
                    begin
                        state_reg <= S_APPLY;
                    end
                end
                S_APPLY:
                begin
                    case (op_reg)
                        OP_INSERT:
                        begin
                            if (not_full)
                            begin
                                count_reg      <= count_reg + CW'(1);
                                res_status_reg <= ST_OK;
                                res_pos_reg    <= POSITION_W'(srch_idx);
                            end
                            else
                            begin
                                res_status_reg <= ST_FULL;
                                res_pos_reg    <= '0;
                            end
                        end
                        OP_SEARCH:
                        begin
                            if (srch.found)
                            begin
                                res_status_reg <= ST_OK;
                                res_pos_reg    <= POSITION_W'(srch_idx);
                            end
                            else
                            begin
                                res_status_reg <= ST_NOT_FOUND;
                                res_pos_reg    <= '0;
                            end
                        end
                        OP_DELETE:
                        begin
                            if (srch.found)
                            begin
                                count_reg      <= count_reg - CW'(1);
                                res_status_reg <= ST_OK;
                                res_pos_reg    <= POSITION_W'(srch_idx);
                            end
                            else
                            begin
                                res_status_reg <= ST_NOT_FOUND;
                                res_pos_reg    <= '0;
                            end
                        end
                        default:
                        begin
                            res_status_reg <= ST_NOT_FOUND;
                            res_pos_reg    <= '0;
                        end
                    endcase
                    state_reg <= S_RESULT;
                end
                S_RESULT:
                begin
                    if (out_free)
                    begin
                        m_tvalid_reg <= 1'b1;
                        m_tdata_reg  <= OUT_TDATA_W'({COUNT_W'(count_reg), res_pos_reg,
                                                      res_status_reg});
                        state_reg    <= S_IDLE;
                    end
                end
                default:
                begin
                    state_reg <= S_IDLE;
                end
            endcase
        end
    end

    assign s_tready = (state_reg == S_IDLE);
    assign m_tvalid = m_tvalid_reg;
    assign m_tdata  = m_tdata_reg;

endmodule

FILE: rtl/core/ssisd_checker.sv
// ----------------------------------------------------------------------------
// Sorted set port checker
// Checks result beats of the sorted set block as seen on its ports.
// ----------------------------------------------------------------------------
module ssisd_checker
    import ssisd_pkg::*;
#(
    parameter int CAPACITY = CAPACITY_DEF
)
(
    input logic                   clk,
    input logic                   rst_n,
    input logic                   s_tvalid,
    input logic                   s_tready,
    input logic [IN_TDATA_W-1:0]  s_tdata,
    input logic                   m_tvalid,
    input logic                   m_tready,
    input logic [OUT_TDATA_W-1:0] m_tdata
);

    localparam logic [COUNT_W-1:0] CAP_COUNT = COUNT_W'(CAPACITY);

    logic [STATUS_W-1:0]   out_status;
    logic [POSITION_W-1:0] out_pos;
    logic [COUNT_W-1:0]    out_count;
    logic                  in_beat;

    assign out_status = m_tdata[STATUS_W-1:0];
    assign out_pos    = m_tdata[STATUS_W +: POSITION_W];
    assign out_count  = m_tdata[STATUS_W + POSITION_W +: COUNT_W];
    assign in_beat    = s_tvalid && s_tready && (s_tdata[0] || !s_tdata[0]);

    a_stall_hold: assert property (@(posedge clk) disable iff (!rst_n)
        m_tvalid && !m_tready |=> m_tvalid && $stable(m_tdata))
        else $error("result beat changed while stalled");

    a_full_count: assert property (@(posedge clk) disable iff (!rst_n)
        m_tvalid && (out_status == ST_FULL) |-> (out_count == CAP_COUNT))
        else $error("full status with list not full");

    a_miss_pos: assert property (@(posedge clk) disable iff (!rst_n)
        m_tvalid && (out_status != ST_OK) |-> (out_pos == '0))
        else $error("nonzero position on a refused or missed operation");

    a_no_early_result: assert property (@(posedge clk) disable iff (!rst_n)
        in_beat |=> !$rose(m_tvalid))
        else $error("result beat one cycle after an input beat");

endmodule

bind sorted_set_insert_search_delete ssisd_checker #(
    .CAPACITY (CAPACITY)
) u_ssisd_checker (
    .clk      (clk),
    .rst_n    (rst_n),
    .s_tvalid (s_tvalid),
    .s_tready (s_tready),
    .s_tdata  (s_tdata),
    .m_tvalid (m_tvalid),
    .m_tready (m_tready),
    .m_tdata  (m_tdata)
);

FILE: sim/sorted_set_insert_search_delete_tb.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// Sorted set testbench
// Sends insert, search, delete and unused-code beats through the stream
// ports. Each accepted input beat is run through a local sorted-list
// predictor, and every result beat is checked field by field against it.
// The run includes a directed opening, a random mix, a fill to a full list
// with refused inserts, and a random mix near capacity. The sender works in
// random bursts and the receiver stalls in random windows.
// ----------------------------------------------------------------------------
module sorted_set_insert_search_delete_tb;
    import ssisd_pkg::*;

    localparam int SET_CAPACITY = CAPACITY_DEF;
    localparam logic [OP_W-1:0] OP_UNUSED = 2'd3;
    localparam logic [VALUE_W-1:0] VALUE_MAX = {VALUE_W{1'b1}};
    localparam int IDLE_LIMIT = 4000;
    localparam int DRAIN_CYCLES = 40;
    localparam int READY_ALWAYS = 0;
    localparam int READY_COIN = 1;
    localparam int READY_HOLD = 2;

    typedef struct {
        logic [OP_W-1:0]    op;
        logic [VALUE_W-1:0] value;
    } request_t;

    typedef struct {
        status_t               status;
        logic [POSITION_W-1:0] position;
        logic [COUNT_W-1:0]    count;
    } reply_t;

    logic                   clk = 1'b0;
    logic                   rst_n = 1'b0;
    logic                   s_tvalid = 1'b0;
    logic                   s_tready;
    logic [IN_TDATA_W-1:0]  s_tdata = '0;
    logic                   m_tvalid;
    logic                   m_tready = 1'b0;
    logic [OUT_TDATA_W-1:0] m_tdata;

    request_t           queued_requests[$];
    reply_t             expected_replies[$];
    logic [VALUE_W-1:0] value_pool[$];

    logic [VALUE_W-1:0] sorted_ids[SET_CAPACITY];
    int                 id_count = 0;

    int mismatch_count = 0;
    int quiet_cycles = 0;
    int burst_left = 0;
    int gap_left = 0;
    int ready_mode = READY_ALWAYS;
    int window_left = 0;

    sorted_set_insert_search_delete #(
        .CAPACITY (SET_CAPACITY)
    ) uut (
        .clk      (clk),
        .rst_n    (rst_n),
        .s_tvalid (s_tvalid),
        .s_tready (s_tready),
        .s_tdata  (s_tdata),
        .m_tvalid (m_tvalid),
        .m_tready (m_tready),
        .m_tdata  (m_tdata)
    );

    always
    begin
        #5 clk = 1'b1;
        #5 clk = 1'b0;
    end

    function automatic int lower_index(logic [VALUE_W-1:0] v);
        int lo;
        int hi;
        int mid;
        lo = 0;
        hi = id_count;
        while (lo < hi)
        begin
            mid = (lo + hi) >> 1;
            if (sorted_ids[mid] >= v)
                hi = mid;
            else
                lo = mid + 1;
        end
        return lo;
    endfunction

    // Midpoint rounded down; returns the first hit reached, or -1.
    function automatic int probe_index(logic [VALUE_W-1:0] v);
        int lo;
        int hi;
        int mid;
        lo = 0;
        hi = id_count - 1;
        while (lo <= hi)
        begin
            mid = (lo + hi) >> 1;
            if (sorted_ids[mid] == v)
                return mid;
            if (sorted_ids[mid] > v)
                hi = mid - 1;
            else
                lo = mid + 1;
        end
        return -1;
    endfunction

    function automatic reply_t apply_request(request_t req);
        reply_t rep;
        int     idx;
        int     i;
        rep.status = ST_NOT_FOUND;
        rep.position = '0;
        case (req.op)
            OP_INSERT:
            begin
                if (id_count >= SET_CAPACITY)
                begin
                    rep.status = ST_FULL;
                end
                else
                begin
                    idx = lower_index(req.value);
                    for (i = id_count; i > idx; i--)
                        sorted_ids[i] = sorted_ids[i-1];
                    sorted_ids[idx] = req.value;
                    id_count++;
                    rep.status = ST_OK;
                    rep.position = idx[POSITION_W-1:0];
                end
            end
            OP_SEARCH:
            begin
                idx = probe_index(req.value);
                if (idx >= 0)
                begin
                    rep.status = ST_OK;
                    rep.position = idx[POSITION_W-1:0];
                end
            end
            OP_DELETE:
            begin
                idx = probe_index(req.value);
                if (idx >= 0)
                begin
                    for (i = idx; i < id_count - 1; i++)
                        sorted_ids[i] = sorted_ids[i+1];
                    id_count--;
                    rep.status = ST_OK;
                    rep.position = idx[POSITION_W-1:0];
                end
            end
            default:
            begin
            end
        endcase
        rep.count = id_count[COUNT_W-1:0];
        return rep;
    endfunction

    task automatic report_mismatch(string msg);
        $display("mismatch at %0t: %s", $time, msg);
        mismatch_count++;
    endtask

    task automatic queue_request(logic [OP_W-1:0] op, logic [VALUE_W-1:0] value);
        request_t req;
        req.op = op;
        req.value = value;
        queued_requests = {queued_requests, req};
        if (op == OP_INSERT)
            value_pool = {value_pool, value};
    endtask

    // Mixes values already used, a small dense range, the top of the range
    // and fully random words.
    function automatic logic [VALUE_W-1:0] pick_value(int pool_pct);
        logic [31:0] word;
        int          roll;
        word = $urandom();
        roll = $urandom_range(0, 99);
        if (roll < pool_pct && value_pool.size() > 0)
            return value_pool[$urandom_range(0, value_pool.size() - 1)];
        if (roll < pool_pct + 20)
            word = $urandom_range(0, 31);
        else if (roll < pool_pct + 25)
            word = {1'b0, VALUE_MAX} - $urandom_range(0, 3);
        return word[VALUE_W-1:0];
    endfunction

    task automatic queue_random_mix(int n, int insert_pct, int delete_pct);
        int roll;
        int k;
        for (k = 0; k < n; k++)
        begin
            roll = $urandom_range(0, 99);
            if (roll < insert_pct)
                queue_request(OP_INSERT, pick_value(25));
            else if (roll < insert_pct + delete_pct)
                queue_request(OP_DELETE, pick_value(70));
            else if (roll < 95)
                queue_request(OP_SEARCH, pick_value(70));
            else
                queue_request(OP_UNUSED, pick_value(30));
        end
    endtask

    task automatic wait_until_drained();
        while (queued_requests.size() != 0 || expected_replies.size() != 0 || s_tvalid)
            @(negedge clk);
    endtask

    always @(posedge clk or negedge rst_n)
    begin : drive_requests
        request_t nxt;
        if (!rst_n)
        begin
            s_tvalid <= 1'b0;
            s_tdata <= '0;
            burst_left <= 0;
            gap_left <= 0;
        end
        else if (!s_tvalid || s_tready)
        begin
            if (gap_left > 0)
            begin
                gap_left <= gap_left - 1;
                s_tvalid <= 1'b0;
            end
            else if (queued_requests.size() > 0)
            begin
                nxt = queued_requests.pop_front();
                s_tdata <= {{(IN_TDATA_W - OP_W - VALUE_W){1'b0}}, nxt.value, nxt.op};
                s_tvalid <= 1'b1;
                if (burst_left <= 1)
                begin
                    burst_left <= $urandom_range(1, 40);
                    gap_left <= ($urandom_range(0, 3) == 0) ? 0 : $urandom_range(1, 15);
                end
                else
                begin
                    burst_left <= burst_left - 1;
                end
            end
            else
            begin
                s_tvalid <= 1'b0;
            end
        end
    end

    always @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            m_tready <= 1'b0;
            ready_mode <= READY_ALWAYS;
            window_left <= 0;
        end
        else
        begin
            if (window_left == 0)
            begin
                ready_mode <= $urandom_range(READY_ALWAYS, READY_HOLD);
                window_left <= $urandom_range(16, 64);
            end
            else
            begin
                window_left <= window_left - 1;
            end
            case (ready_mode)
                READY_ALWAYS: m_tready <= 1'b1;
                READY_COIN:   m_tready <= 1'($urandom_range(0, 1));
                default:      m_tready <= 1'b0;
            endcase
        end
    end

    always @(posedge clk)
    begin : check_replies
        reply_t   want;
        request_t got;
        if (rst_n)
        begin
            if (m_tvalid && m_tready)
            begin
                if (expected_replies.size() == 0)
                begin
                    report_mismatch($sformatf("result beat %h with nothing expected", m_tdata));
                end
                else
                begin
                    want = expected_replies.pop_front();
                    if (m_tdata[STATUS_W-1:0] != want.status)
                        report_mismatch($sformatf("status %0d, expected %0d",
                            m_tdata[STATUS_W-1:0], want.status));
                    if (m_tdata[STATUS_W +: POSITION_W] != want.position)
                        report_mismatch($sformatf("position %0d, expected %0d",
                            m_tdata[STATUS_W +: POSITION_W], want.position));
                    if (m_tdata[STATUS_W + POSITION_W +: COUNT_W] != want.count)
                        report_mismatch($sformatf("count %0d, expected %0d",
                            m_tdata[STATUS_W + POSITION_W +: COUNT_W], want.count));
                end
            end
            if (s_tvalid && s_tready)
            begin
                got.op = s_tdata[OP_W-1:0];
                got.value = s_tdata[OP_W +: VALUE_W];
                expected_replies = {expected_replies, apply_request(got)};
            end
        end
    end

    always @(posedge clk)
    begin
        if ((s_tvalid && s_tready) || (m_tvalid && m_tready) || !rst_n)
        begin
            quiet_cycles <= 0;
        end
        else if (quiet_cycles >= IDLE_LIMIT)
        begin
            $display("[sorted_set_insert_search_delete] ERROR");
            $finish;
        end
        else
        begin
            quiet_cycles <= quiet_cycles + 1;
        end
    end

    initial
    begin : run_phases
        int fill;
        int k;
        repeat (6) @(posedge clk);
        rst_n <= 1'b1;

        // Empty list, unused code, both ends of the range and duplicates.
        queue_request(OP_SEARCH, 31'd5);
        queue_request(OP_DELETE, 31'd5);
        queue_request(OP_UNUSED, VALUE_MAX);
        queue_request(OP_INSERT, VALUE_MAX);
        queue_request(OP_INSERT, 31'd0);
        queue_request(OP_INSERT, VALUE_MAX);
        queue_request(OP_INSERT, 31'd100);
        queue_request(OP_INSERT, 31'd100);
        queue_request(OP_INSERT, 31'd100);
        queue_request(OP_SEARCH, 31'd100);
        queue_request(OP_SEARCH, 31'd0);
        queue_request(OP_SEARCH, VALUE_MAX);
        queue_request(OP_SEARCH, 31'd50);
        queue_request(OP_DELETE, 31'd50);
        queue_request(OP_DELETE, 31'd100);
        queue_request(OP_UNUSED, 31'h2AAAAAAA);
        queue_request(OP_DELETE, 31'd0);
        queue_request(OP_SEARCH, 31'd0);
        queue_request(OP_INSERT, 31'h55555555);
        queue_request(OP_DELETE, VALUE_MAX);

        queue_random_mix(80, 45, 25);

        // The sender holds off here until every result is back.
        wait_until_drained();

        fill = SET_CAPACITY - id_count;
        k = 0;
        while (k < fill)
        begin
            if ($urandom_range(0, 19) == 0)
            begin
                queue_request(OP_SEARCH, pick_value(70));
            end
            else
            begin
                queue_request(OP_INSERT, pick_value(25));
                k++;
            end
        end
        for (k = 0; k < 10; k++)
            queue_request(OP_INSERT, pick_value(25));

        queue_random_mix(60, 30, 40);

        wait_until_drained();
        repeat (DRAIN_CYCLES) @(posedge clk);
        if (mismatch_count == 0)
            $display("[sorted_set_insert_search_delete] OK");
        else
            $display("[sorted_set_insert_search_delete] ERROR");
        $finish;
    end

endmodule
